@@ src/smsp_pkg.sv @@
// Shared constants for the shuffled minimal-standard random source.
// No dependencies; imported by smsp_mulmod, smsp_index and the core.
package smsp_pkg;

  localparam int unsigned WORD_W = 31;
  localparam int unsigned MULT_W = 15;

  localparam logic [WORD_W-1:0] MODULUS = 31'h7FFF_FFFF;  // 2^31 - 1
  localparam logic [MULT_W-1:0] PM_MULT = 15'd16807;
  localparam int unsigned       WARMUP  = 8;

endpackage

@@ src/smsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smsp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/smsp_mulmod.sv @@
// One generator step: y = 16807 * x mod (2^31 - 1).
// Product registered, folding reduction combinational after it. Uses smsp_pkg.
module smsp_mulmod import smsp_pkg::*; (
  input  logic              clk_i,
  input  logic [WORD_W-1:0] x_i,
  output logic [WORD_W-1:0] y_o
);

  localparam int unsigned PROD_W = WORD_W + MULT_W;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic [WORD_W:0]   fold;
  logic [WORD_W:0]   fold_sub;

  assign prod_d = PROD_W'(x_i) * PROD_W'(PM_MULT);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // 2^31 == 1 mod M: add high part onto low part, then one conditional subtract
  assign fold     = (WORD_W+1)'(prod_q[PROD_W-1:WORD_W]) + (WORD_W+1)'(prod_q[WORD_W-1:0]);
  assign fold_sub = fold - (WORD_W+1)'(MODULUS);
  assign y_o      = (fold >= (WORD_W+1)'(MODULUS)) ? fold_sub[WORD_W-1:0] : fold[WORD_W-1:0];

endmodule

@@ src/smsp_index.sv @@
// Table index from last output: last / (1 + (M-1)/TABLE_SIZE), saturated.
// Reciprocal multiply (registered) then one correction step. Uses smsp_pkg.
module smsp_index import smsp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic [WORD_W-1:0]             v_i,
  output logic [$clog2(TABLE_SIZE)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned QW = $clog2(TABLE_SIZE + 1);
  localparam longint unsigned DIVISOR =
    64'd1 + (64'(MODULUS) - 64'd1) / 64'(TABLE_SIZE);
  localparam int unsigned DW    = $clog2(DIVISOR);
  localparam int unsigned SHIFT = 30 + DW;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIVISOR;
  localparam int unsigned PW = WORD_W + 32;
  localparam int unsigned TW = WORD_W + 2;

  logic [PW-1:0]     prod_q;
  logic [WORD_W-1:0] v_q;
  logic [IW-1:0]     idx_q;
  logic [31:0]       recip_c;
  logic [QW-1:0]     q_est;
  logic [TW-1:0]     thr;
  logic              ge;
  logic [QW:0]       q_full;
  logic [IW-1:0]     idx_d;

  assign recip_c = RECIP[31:0];

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(v_i) * PW'(recip_c);
    v_q    <= v_i;
    idx_q  <= idx_d;
  end

  // estimate is the true quotient or one below it
  assign q_est  = prod_q[SHIFT +: QW];
  assign thr    = (TW'(q_est) + TW'(1)) * TW'(DIVISOR);
  assign ge     = TW'(v_q) >= thr;
  assign q_full = (QW+1)'(q_est) + (QW+1)'(ge);
  assign idx_d  = (q_full >= (QW+1)'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : q_full[IW-1:0];
  assign idx_o  = idx_q;

endmodule

@@ src/shuffled_minimal_standard_prng_core.sv @@
// Park-Miller minimal-standard generator with a Bays-Durham shuffle table.
// Plain draw: read at accept; ST_DRAW swaps the entry and registers the
// result when the output is free; ST_IDX_A/B then run before a new request.
// After reset or with restart set, TABLE_SIZE+WARMUP fill steps come first.
// Reset (async, active low): seed = 1, generator = 1, table unloaded, no result.
// Depends on smsp_pkg, smsp_ram, smsp_mulmod, smsp_index.
module shuffled_minimal_standard_prng_core import smsp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel (seed register)
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_seed_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              restart_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] deviate_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + WARMUP);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT_A = 3'd1;  // product forming
  localparam logic [2:0] ST_INIT_B = 3'd2;  // take step, fill entry
  localparam logic [2:0] ST_IDX_A  = 3'd3;  // index pipeline stage 1
  localparam logic [2:0] ST_IDX_B  = 3'd4;  // index pipeline stage 2
  localparam logic [2:0] ST_READ   = 3'd5;  // table read after a fill
  localparam logic [2:0] ST_DRAW   = 3'd6;  // swap entry, emit item

  logic [2:0]        state_q, state_d;
  logic [WORD_W-1:0] seed_q, seed_d;
  logic [WORD_W-1:0] gen_q, gen_d;
  logic [WORD_W-1:0] last_q, last_d;
  logic              loaded_q, loaded_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] deviate_q, deviate_d;

  logic              in_acc;
  logic              out_free;
  logic [WORD_W-1:0] seed_eff;
  logic [WORD_W-1:0] step_w;
  logic [IW-1:0]     idx_w;
  logic [WORD_W-1:0] rdata_w;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic              ram_re;

  // ---------------------------------------------------------------------------
  // Datapath units
  // ---------------------------------------------------------------------------
  // Generator step: product registered from gen_q, fold is combinational, so
  // step_w follows gen_q in the cycle after gen_q changes.
  smsp_mulmod u_mulmod (
    .clk_i (clk_i),
    .x_i   (gen_q),
    .y_o   (step_w)
  );

  // Index of the next entry to pick: registered product, then registered index.
  smsp_index #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_index (
    .clk_i (clk_i),
    .v_i   (last_q),
    .idx_o (idx_w)
  );

  // Shuffle table. Reads and writes of one entry are kept apart by the
  // sequencer: a read at ST_IDLE/ST_READ, the write at ST_DRAW after it.
  smsp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (step_w),
    .re_i    (ram_re),
    .raddr_i (idx_w),
    .rdata_o (rdata_w)
  );

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // seed 0 and seed == M both reduce to 0, which becomes 1
  assign seed_eff = ((seed_q == '0) || (seed_q == MODULUS)) ? WORD_W'(1) : seed_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    gen_d       = gen_q;
    last_d      = last_q;
    loaded_d    = loaded_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    deviate_d   = deviate_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_w;
    ram_re      = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      seed_d = cfg_seed_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (restart_i || !loaded_q) begin
            gen_d   = seed_eff;
            cnt_d   = CW'(TABLE_SIZE + WARMUP - 1);
            pend_d  = 1'b1;
            state_d = ST_INIT_A;
          end else begin
            ram_re  = 1'b1;
            state_d = ST_DRAW;
          end
        end
      end
      ST_INIT_A: begin
        state_d = ST_INIT_B;
      end
      ST_INIT_B: begin
        gen_d = step_w;
        if (cnt_q < CW'(TABLE_SIZE)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[IW-1:0];
        end
        if (cnt_q == '0) begin
          // last output starts as entry 0, the value just written
          last_d   = step_w;
          loaded_d = 1'b1;
          state_d  = ST_IDX_A;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_INIT_A;
        end
      end
      ST_IDX_A: begin
        state_d = ST_IDX_B;
      end
      ST_IDX_B: begin
        if (pend_q) begin
          pend_d  = 1'b0;
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        // hold here while the previous item still waits at the output
        if (out_free) begin
          ram_we      = 1'b1;
          ram_waddr   = idx_w;
          gen_d       = step_w;
          last_d      = rdata_w;
          deviate_d   = rdata_w;
          out_valid_d = 1'b1;
          state_d     = ST_IDX_A;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= WORD_W'(1);
      gen_q       <= WORD_W'(1);
      last_q      <= '0;
      loaded_q    <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      gen_q       <= gen_d;
      last_q      <= last_d;
      loaded_q    <= loaded_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deviate_q <= deviate_d;
  end

  assign out_valid_o = out_valid_q;
  assign deviate_o   = deviate_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // generator never leaves 1..M-1
  a_gen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_q != '0) && (gen_q != MODULUS))
    else $error("generator value out of range");

  // a delivered item is always in 1..M-1
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((deviate_o != '0) && (deviate_o != MODULUS)))
    else $error("deviate out of range");

  // an accepted item always leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_INIT_A) || (state_q == ST_DRAW))
    else $error("accepted item did not start work");

  // table writes only during fill or at the swap of a draw
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_INIT_B) || ((state_q == ST_DRAW) && out_free))
    else $error("unexpected table write");

endmodule
